>>> hw/rtl/tcprx_pkg.sv
// Shared types, codes and helper functions of the TCP receive state machine.
package tcprx_pkg;

	// Wire encoding of the connection state
	localparam logic [3:0] CODE_CLOSED    = 4'd0;
	localparam logic [3:0] CODE_LISTEN    = 4'd1;
	localparam logic [3:0] CODE_SYN_SENT  = 4'd2;
	localparam logic [3:0] CODE_SYN_RCVD  = 4'd3;
	localparam logic [3:0] CODE_ESTAB     = 4'd4;
	localparam logic [3:0] CODE_FINWAIT1  = 4'd5;
	localparam logic [3:0] CODE_FINWAIT2  = 4'd6;
	localparam logic [3:0] CODE_CLOSING   = 4'd7;
	localparam logic [3:0] CODE_TIMEWAIT  = 4'd8;
	localparam logic [3:0] CODE_CLOSEWAIT = 4'd9;
	localparam logic [3:0] CODE_LASTACK   = 4'd10;

	// Internal one-hot connection state
	typedef enum logic [10:0] {
		ST_CLOSED    = 11'b000_0000_0001,
		ST_LISTEN    = 11'b000_0000_0010,
		ST_SYN_SENT  = 11'b000_0000_0100,
		ST_SYN_RCVD  = 11'b000_0000_1000,
		ST_ESTAB     = 11'b000_0001_0000,
		ST_FINWAIT1  = 11'b000_0010_0000,
		ST_FINWAIT2  = 11'b000_0100_0000,
		ST_CLOSING   = 11'b000_1000_0000,
		ST_TIMEWAIT  = 11'b001_0000_0000,
		ST_CLOSEWAIT = 11'b010_0000_0000,
		ST_LASTACK   = 11'b100_0000_0000
	} conn_state_t;

	typedef enum logic [1:0] {
		ACT_NONE   = 2'd0,
		ACT_RESET  = 2'd1,
		ACT_ACK    = 2'd2,
		ACT_SYNACK = 2'd3
	} send_action_t;

	typedef enum logic [1:0] {
		NFY_NONE        = 2'd0,
		NFY_CONNECTED   = 2'd1,
		NFY_PEER_CLOSED = 2'd2,
		NFY_RESET       = 2'd3
	} notify_t;

	// One input word
	typedef struct packed {
		logic        command;
		logic [3:0]  new_state;
		logic        flag_syn;
		logic        flag_ack;
		logic        flag_rst;
		logic        flag_fin;
		logic [31:0] seg_seq;
		logic [31:0] seg_ack;
		logic [31:0] send_next;
	} seg_word_t;

	// One result word
	typedef struct packed {
		logic [3:0]   conn_state_out;
		send_action_t send_action;
		notify_t      notify;
		logic         rejected;
		logic [31:0]  unacked_seq;
		logic [31:0]  recv_next_seq;
	} res_word_t;

	// Per-connection context
	typedef struct packed {
		conn_state_t state;
		logic [31:0] send_unacked;
		logic [31:0] recv_next;
	} conn_ctx_t;

	// Serial compare: a before b
	function automatic logic ser_lt(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] diff;
		diff = a - b;
		return diff[31];
	endfunction

	// Serial compare: a after b
	function automatic logic ser_gt(input logic [31:0] a, input logic [31:0] b);
		return (a != b) && !ser_lt(a, b);
	endfunction

	function automatic logic [3:0] state_encode(input conn_state_t s);
		logic [3:0] code;
		case (s)
			ST_CLOSED:    code = CODE_CLOSED;
			ST_LISTEN:    code = CODE_LISTEN;
			ST_SYN_SENT:  code = CODE_SYN_SENT;
			ST_SYN_RCVD:  code = CODE_SYN_RCVD;
			ST_ESTAB:     code = CODE_ESTAB;
			ST_FINWAIT1:  code = CODE_FINWAIT1;
			ST_FINWAIT2:  code = CODE_FINWAIT2;
			ST_CLOSING:   code = CODE_CLOSING;
			ST_TIMEWAIT:  code = CODE_TIMEWAIT;
			ST_CLOSEWAIT: code = CODE_CLOSEWAIT;
			ST_LASTACK:   code = CODE_LASTACK;
			default:      code = CODE_CLOSED;
		endcase
		return code;
	endfunction

	// Codes above lastack must be screened by the caller
	function automatic conn_state_t state_decode(input logic [3:0] code);
		conn_state_t s;
		case (code)
			CODE_CLOSED:    s = ST_CLOSED;
			CODE_LISTEN:    s = ST_LISTEN;
			CODE_SYN_SENT:  s = ST_SYN_SENT;
			CODE_SYN_RCVD:  s = ST_SYN_RCVD;
			CODE_ESTAB:     s = ST_ESTAB;
			CODE_FINWAIT1:  s = ST_FINWAIT1;
			CODE_FINWAIT2:  s = ST_FINWAIT2;
			CODE_CLOSING:   s = ST_CLOSING;
			CODE_TIMEWAIT:  s = ST_TIMEWAIT;
			CODE_CLOSEWAIT: s = ST_CLOSEWAIT;
			CODE_LASTACK:   s = ST_LASTACK;
			default:        s = ST_CLOSED;
		endcase
		return s;
	endfunction

endpackage

>>> hw/rtl/tcprx_if.sv
// Handshake channel interfaces: segment input, result output, configuration write.
interface tcprx_seg_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [3:0]  new_state;
	logic        flag_syn;
	logic        flag_ack;
	logic        flag_rst;
	logic        flag_fin;
	logic [31:0] seg_seq;
	logic [31:0] seg_ack;
	logic [31:0] send_next;

	modport source (
		output valid, command, new_state, flag_syn, flag_ack, flag_rst, flag_fin,
		output seg_seq, seg_ack, send_next,
		input  ready
	);
	modport sink (
		input  valid, command, new_state, flag_syn, flag_ack, flag_rst, flag_fin,
		input  seg_seq, seg_ack, send_next,
		output ready
	);
endinterface

interface tcprx_res_if;
	logic        valid;
	logic        ready;
	logic [3:0]  conn_state_out;
	logic [1:0]  send_action;
	logic [1:0]  notify;
	logic        rejected;
	logic [31:0] unacked_seq;
	logic [31:0] recv_next_seq;

	modport source (
		output valid, conn_state_out, send_action, notify, rejected,
		output unacked_seq, recv_next_seq,
		input  ready
	);
	modport sink (
		input  valid, conn_state_out, send_action, notify, rejected,
		input  unacked_seq, recv_next_seq,
		output ready
	);
endinterface

interface tcprx_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

>>> hw/rtl/tcprx_step.sv
// Next-state and result logic for one segment or local state load.
module tcprx_step (
	input  tcprx_pkg::seg_word_t w,
	input  tcprx_pkg::conn_ctx_t cur,
	input  logic [31:0]          send_initial_seq,
	output tcprx_pkg::conn_ctx_t nxt,
	output tcprx_pkg::res_word_t res
);
	import tcprx_pkg::*;

	send_action_t act;
	notify_t      nfy;
	logic         rej;
	logic         data_fin;
	logic         synced;
	logic         ack_ok;
	logic [31:0]  una_acc;
	logic         fin_acked;
	logic         bad_ack;

	// Compares against the current context and the initial sequence
	always_comb begin
		ack_ok    = w.flag_ack && !ser_lt(w.seg_ack, cur.send_unacked)
			&& !ser_gt(w.seg_ack, w.send_next);
		una_acc   = ack_ok ? w.seg_ack : cur.send_unacked;
		fin_acked = ser_gt(w.seg_ack, cur.send_unacked);
		bad_ack   = !ser_gt(w.seg_ack, send_initial_seq) || ser_gt(w.seg_ack, w.send_next);
		synced    = cur.state inside {ST_ESTAB, ST_FINWAIT1, ST_FINWAIT2, ST_CLOSING,
			ST_TIMEWAIT, ST_CLOSEWAIT, ST_LASTACK};
	end

	// Advance the connection state
	always_comb begin
		nxt      = cur;
		act      = ACT_NONE;
		nfy      = NFY_NONE;
		rej      = 1'b0;
		data_fin = 1'b0;
		if (w.command) begin
			if (w.new_state <= CODE_LASTACK)
				nxt.state = state_decode(w.new_state);
		end else if (synced && w.flag_syn) begin
			act = ACT_RESET;
			rej = 1'b1;
		end else if (synced && w.flag_rst && w.flag_ack) begin
			nxt.state = ST_CLOSED;
			nfy       = NFY_RESET;
		end else begin
			case (cur.state)
				ST_CLOSED: begin
					if (!w.flag_rst)
						act = ACT_RESET;
				end
				ST_SYN_SENT: begin
					if (bad_ack) begin
						act = ACT_RESET;
						rej = 1'b1;
					end else if (w.flag_rst && w.flag_ack) begin
						nxt.state = ST_CLOSED;
						nfy       = NFY_RESET;
					end else if (w.flag_syn) begin
						nxt.recv_next = w.seg_seq + 32'd1;
						if (w.flag_ack) begin
							nxt.send_unacked = cur.send_unacked + 32'd1;
							act              = ACT_ACK;
							nxt.state        = ST_ESTAB;
							nfy              = NFY_CONNECTED;
						end else begin
							nxt.state = ST_SYN_RCVD;
							act       = ACT_SYNACK;
						end
					end
				end
				ST_ESTAB, ST_CLOSEWAIT: begin
					nxt.send_unacked = una_acc;
					if (w.flag_fin)
						nxt.state = ST_CLOSEWAIT;
					data_fin = w.flag_fin;
				end
				ST_FINWAIT1: begin
					if (w.flag_fin)
						nxt.state = fin_acked ? ST_TIMEWAIT : ST_CLOSING;
					else
						nxt.state = ST_FINWAIT2;
					nxt.send_unacked = una_acc;
					data_fin         = w.flag_fin;
				end
				ST_FINWAIT2: begin
					nxt.send_unacked = una_acc;
					if (w.flag_fin)
						nxt.state = ST_TIMEWAIT;
					data_fin = w.flag_fin;
				end
				ST_CLOSING: begin
					if (fin_acked)
						nxt.state = ST_TIMEWAIT;
					nxt.send_unacked = una_acc;
				end
				ST_TIMEWAIT: begin
					nxt.send_unacked = una_acc;
					if (w.flag_fin)
						act = ACT_ACK;
				end
				ST_LASTACK: begin
					if (w.flag_ack) begin
						nxt.state = ST_CLOSED;
						nfy       = NFY_PEER_CLOSED;
					end
				end
				default: begin
					// listen and syn_rcvd drop segments
				end
			endcase
			// Acknowledge a peer FIN
			if (data_fin) begin
				nxt.recv_next = cur.recv_next + 32'd1;
				nfy           = NFY_PEER_CLOSED;
				act           = ACT_ACK;
			end
		end
	end

	// Pack the result word
	always_comb begin
		res.conn_state_out = state_encode(nxt.state);
		res.send_action    = act;
		res.notify         = nfy;
		res.rejected       = rej;
		res.unacked_seq    = nxt.send_unacked;
		res.recv_next_seq  = nxt.recv_next;
	end

endmodule

>>> hw/rtl/tcp_connection_receive_fsm.sv
// Top level of the per-connection TCP receive state machine.
//
//   channel  dir  handshake      word
//   seg      in   valid/ready    command, new_state, flags, seg_seq, seg_ack, send_next
//   res      out  valid/ready    conn_state_out, send_action, notify, rejected, seqs
//   cfg      in   valid/ready    send_initial_seq (always ready)
//
// One word per cycle unless results stall; words go through word and result registers.
// The word register feeds the state logic, whose outcome updates the context and
// the result register in the same cycle, so the next word sees the new context.
// A stalled result holds the word register; input stalls only when both are full.
// Reset clears the context to closed with zero sequences and the initial sequence to 0.
module tcp_connection_receive_fsm (
	input  logic        clk,
	input  logic        arst_n,
	tcprx_seg_if.sink   seg,
	tcprx_res_if.source res,
	tcprx_cfg_if.sink   cfg
);
	import tcprx_pkg::*;

	seg_word_t  seg_word;
	seg_word_t  seg_s1;
	logic       valid_s1;
	conn_ctx_t  ctx_q;
	conn_ctx_t  ctx_next;
	res_word_t  res_word;
	res_word_t  res_q;
	logic       res_valid_q;
	logic [31:0] isn_q;
	logic       advance;

	assign seg_word = '{
		command:   seg.command,
		new_state: seg.new_state,
		flag_syn:  seg.flag_syn,
		flag_ack:  seg.flag_ack,
		flag_rst:  seg.flag_rst,
		flag_fin:  seg.flag_fin,
		seg_seq:   seg.seg_seq,
		seg_ack:   seg.seg_ack,
		send_next: seg.send_next
	};

	// Handshake control
	assign advance   = valid_s1 && (!res_valid_q || res.ready);
	assign seg.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	// Capture the configuration word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			isn_q <= '0;
		end else if (cfg.valid) begin
			isn_q <= cfg.data;
		end
	end

	// Input word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (seg.ready) begin
			valid_s1 <= seg.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (seg.valid && seg.ready)
			seg_s1 <= seg_word;
	end

	tcprx_step u_step (
		.w                (seg_s1),
		.cur              (ctx_q),
		.send_initial_seq (isn_q),
		.nxt              (ctx_next),
		.res              (res_word)
	);

	// Commit the context when the word moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q <= '{state: ST_CLOSED, send_unacked: '0, recv_next: '0};
		end else if (advance) begin
			ctx_q <= ctx_next;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res_word;
	end

	assign res.valid          = res_valid_q;
	assign res.conn_state_out = res_q.conn_state_out;
	assign res.send_action    = res_q.send_action;
	assign res.notify         = res_q.notify;
	assign res.rejected       = res_q.rejected;
	assign res.unacked_seq    = res_q.unacked_seq;
	assign res.recv_next_seq  = res_q.recv_next_seq;

	// Input stalls only when both registers are full and the output is held
	assert property (@(posedge clk) disable iff (!arst_n)
		!seg.ready |-> (valid_s1 && res_valid_q && !res.ready))
		else $error("input stalled without a full pipeline");

	// Context moves only when a word is processed
	assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(ctx_q))
		else $error("context changed without a word");

	// A processed word always shows up as a result
	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_valid_q)
		else $error("processed word lost");

	// A rejected segment is always answered with a reset
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.rejected) |-> (res_q.send_action == ACT_RESET))
		else $error("reject without reset action");

	// Connected is reported only on entry to estab
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.notify == NFY_CONNECTED)
			|-> (res_q.conn_state_out == CODE_ESTAB))
		else $error("connected notify outside estab");

endmodule

>>> tb/tcp_connection_receive_fsm_tb.sv
// Testbench for the TCP receive state machine: predicts each result and checks it.
module tcp_connection_receive_fsm_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tcprx_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int PHASE_WORDS = 200;

	// Tracks one connection and holds the results it still owes
	class conn_tracker;
		logic [31:0] isn;
		logic [3:0]  st;
		logic [31:0] snd_una;
		logic [31:0] rcv_nxt;
		res_word_t   due[$];
		int          mismatches;

		function new();
			isn = '0;
			st = CODE_CLOSED;
			snd_una = '0;
			rcv_nxt = '0;
			mismatches = 0;
		endfunction

		// a comes earlier than b in sequence space
		function bit seq_before(logic [31:0] a, logic [31:0] b);
			logic [31:0] d;
			d = a - b;
			return d[31];
		endfunction

		// a comes later than b in sequence space
		function bit seq_after(logic [31:0] a, logic [31:0] b);
			logic [31:0] d;
			d = a - b;
			return (d != '0) && !d[31];
		endfunction

		// Advance the oldest unacked pointer when the ack falls inside the send window
		function void take_ack(seg_word_t w);
			if (w.flag_ack && !seq_before(w.seg_ack, snd_una) &&
			    !seq_after(w.seg_ack, w.send_next))
				snd_una = w.seg_ack;
		endfunction

		// Work out the result of one accepted word and queue it
		function void note_segment(seg_word_t w);
			res_word_t  r;
			logic [3:0] was;
			bit         fin_taken;
			r.send_action = ACT_NONE;
			r.notify = NFY_NONE;
			r.rejected = 1'b0;
			was = st;
			fin_taken = 1'b0;
			if (w.command) begin
				if (w.new_state <= CODE_LASTACK)
					st = w.new_state;
			end else if (was == CODE_CLOSED) begin
				if (!w.flag_rst)
					r.send_action = ACT_RESET;
			end else if (was == CODE_LISTEN || was == CODE_SYN_RCVD || was > CODE_LASTACK) begin
				// drop the segment
			end else if (was == CODE_SYN_SENT) begin
				if (!seq_after(w.seg_ack, isn) || seq_after(w.seg_ack, w.send_next)) begin
					r.send_action = ACT_RESET;
					r.rejected = 1'b1;
				end else if (w.flag_rst && w.flag_ack) begin
					st = CODE_CLOSED;
					r.notify = NFY_RESET;
				end else if (w.flag_syn) begin
					rcv_nxt = w.seg_seq + 32'd1;
					if (w.flag_ack) begin
						snd_una = snd_una + 32'd1;
						r.send_action = ACT_ACK;
						st = CODE_ESTAB;
						r.notify = NFY_CONNECTED;
					end else begin
						st = CODE_SYN_RCVD;
						r.send_action = ACT_SYNACK;
					end
				end
			end else if (w.flag_syn) begin
				r.send_action = ACT_RESET;
				r.rejected = 1'b1;
			end else if (w.flag_rst && w.flag_ack) begin
				st = CODE_CLOSED;
				r.notify = NFY_RESET;
			end else begin
				case (was)
					CODE_ESTAB, CODE_CLOSEWAIT: begin
						take_ack(w);
						if (w.flag_fin)
							st = CODE_CLOSEWAIT;
						fin_taken = w.flag_fin;
					end
					CODE_FINWAIT1: begin
						// decide on the pointer as it stood before this ack
						if (w.flag_fin)
							st = seq_after(w.seg_ack, snd_una) ? CODE_TIMEWAIT : CODE_CLOSING;
						else
							st = CODE_FINWAIT2;
						take_ack(w);
						fin_taken = w.flag_fin;
					end
					CODE_FINWAIT2: begin
						take_ack(w);
						if (w.flag_fin)
							st = CODE_TIMEWAIT;
						fin_taken = w.flag_fin;
					end
					CODE_CLOSING: begin
						if (seq_after(w.seg_ack, snd_una))
							st = CODE_TIMEWAIT;
						take_ack(w);
					end
					CODE_TIMEWAIT: begin
						take_ack(w);
						if (w.flag_fin)
							r.send_action = ACT_ACK;
					end
					default: begin
						if (w.flag_ack) begin
							st = CODE_CLOSED;
							r.notify = NFY_PEER_CLOSED;
						end
					end
				endcase
				if (fin_taken) begin
					rcv_nxt = rcv_nxt + 32'd1;
					r.notify = NFY_PEER_CLOSED;
					r.send_action = ACT_ACK;
				end
			end
			r.conn_state_out = st;
			r.unacked_seq = snd_una;
			r.recv_next_seq = rcv_nxt;
			due.push_back(r);
		endfunction

		// Compare one result against the oldest outstanding one
		function void check_result(res_word_t got);
			res_word_t want;
			if (due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%t: result with nothing outstanding: state %0d action %0d",
						$realtime, got.conn_state_out, got.send_action);
				return;
			end
			want = due.pop_front();
			if (got.conn_state_out !== want.conn_state_out ||
			    got.send_action !== want.send_action || got.notify !== want.notify ||
			    got.rejected !== want.rejected || got.unacked_seq !== want.unacked_seq ||
			    got.recv_next_seq !== want.recv_next_seq) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%t: mismatch, expected / actual:", $realtime);
					$display("  state %0d / %0d  action %0d / %0d  notify %0d / %0d",
						want.conn_state_out, got.conn_state_out, want.send_action,
						got.send_action, want.notify, got.notify);
					$display("  rejected %0d / %0d  unacked %h / %h  recv_next %h / %h",
						want.rejected, got.rejected, want.unacked_seq, got.unacked_seq,
						want.recv_next_seq, got.recv_next_seq);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	tcprx_seg_if seg();
	tcprx_res_if res();
	tcprx_cfg_if cfg();

	tcp_connection_receive_fsm dut (
		.clk    (clk),
		.arst_n (arst_n),
		.seg    (seg),
		.res    (res),
		.cfg    (cfg)
	);

	conn_tracker trk;
	bit          src_steady;
	int unsigned cycle_count = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Mostly short idle stretches, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic seg_word_t seg_of(bit syn, bit ack, bit rst, bit fin,
		logic [31:0] sq, logic [31:0] ak, logic [31:0] nx);
		seg_word_t w;
		w.command = 1'b0;
		w.new_state = CODE_CLOSED;
		w.flag_syn = syn;
		w.flag_ack = ack;
		w.flag_rst = rst;
		w.flag_fin = fin;
		w.seg_seq = sq;
		w.seg_ack = ak;
		w.send_next = nx;
		return w;
	endfunction

	function automatic seg_word_t load_of(logic [3:0] s);
		seg_word_t w;
		w = seg_of(1'b0, 1'b0, 1'b0, 1'b0, '0, '0, '0);
		w.command = 1'b1;
		w.new_state = s;
		return w;
	endfunction

	// Build the next random word, steered by the predicted connection state
	function automatic seg_word_t next_segment();
		seg_word_t   w;
		int          roll;
		int          load_pct;
		int unsigned span;
		w.command = 1'b0;
		w.new_state = 4'($urandom_range(0, 15));
		w.flag_syn = 1'($urandom_range(0, 1));
		w.flag_ack = 1'($urandom_range(0, 1));
		w.flag_rst = 1'($urandom_range(0, 1));
		w.flag_fin = 1'($urandom_range(0, 1));
		w.seg_seq = $urandom;
		w.seg_ack = $urandom;
		w.send_next = $urandom;
		roll = $urandom_range(0, 99);
		// pure noise
		if (roll < 8) begin
			w.command = 1'($urandom_range(0, 1));
			return w;
		end
		case (trk.st)
			CODE_CLOSED, CODE_LISTEN, CODE_SYN_RCVD: load_pct = 60;
			CODE_CLOSEWAIT, CODE_TIMEWAIT:           load_pct = 25;
			default:                                 load_pct = 6;
		endcase
		// local command, usually the next step of a normal connection life
		if (roll < 8 + load_pct) begin
			w.command = 1'b1;
			if ($urandom_range(0, 3) != 0) begin
				case (trk.st)
					CODE_CLOSED, CODE_LISTEN, CODE_SYN_RCVD: w.new_state = CODE_SYN_SENT;
					CODE_CLOSEWAIT: w.new_state = CODE_LASTACK;
					CODE_TIMEWAIT:  w.new_state = CODE_CLOSED;
					CODE_ESTAB:     w.new_state = CODE_FINWAIT1;
					default:        w.new_state = 4'($urandom_range(0, 10));
				endcase
			end
			return w;
		end
		if (trk.st == CODE_SYN_SENT) begin
			span = $urandom_range(1, 4096);
			w.send_next = trk.isn + span;
			if ($urandom_range(0, 9) != 0)
				w.seg_ack = trk.isn + $urandom_range(1, span);
			else
				w.seg_ack = trk.isn + $urandom_range(0, 8192);
			w.flag_syn = ($urandom_range(0, 9) < 8);
			w.flag_rst = ($urandom_range(0, 7) == 0);
		end else begin
			span = $urandom_range(0, 4096);
			w.send_next = trk.snd_una + span;
			roll = $urandom_range(0, 9);
			if (roll == 0)
				w.seg_ack = trk.snd_una - $urandom_range(1, 64);
			else if (roll == 1)
				w.seg_ack = w.send_next + $urandom_range(1, 64);
			else
				w.seg_ack = trk.snd_una + $urandom_range(0, span);
			w.seg_seq = trk.rcv_nxt + $urandom_range(0, 1500);
			w.flag_syn = ($urandom_range(0, 24) == 0);
			w.flag_rst = ($urandom_range(0, 11) == 0);
			w.flag_ack = ($urandom_range(0, 9) < 8);
			w.flag_fin = ($urandom_range(0, 3) == 0);
		end
		return w;
	endfunction

	// Offer one word, hold it until taken, then record it
	task automatic send_word(input seg_word_t w);
		int gap;
		gap = src_steady ? 0 : idle_len();
		if (gap > 0) begin
			seg.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		seg.valid <= 1'b1;
		seg.command <= w.command;
		seg.new_state <= w.new_state;
		seg.flag_syn <= w.flag_syn;
		seg.flag_ack <= w.flag_ack;
		seg.flag_rst <= w.flag_rst;
		seg.flag_fin <= w.flag_fin;
		seg.seg_seq <= w.seg_seq;
		seg.seg_ack <= w.seg_ack;
		seg.send_next <= w.send_next;
		@(posedge clk);
		while (!seg.ready)
			@(posedge clk);
		trk.note_segment(w);
	endtask

	// Stop offering and wait until every outstanding result has come back
	task automatic drain();
		seg.valid <= 1'b0;
		do
			@(posedge clk);
		while (trk.due.size() != 0);
	endtask

	task automatic write_isn(input logic [31:0] v);
		cfg.valid <= 1'b1;
		cfg.data <= v;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		cfg.valid <= 1'b0;
		trk.isn = v;
	endtask

	// Check every result word taken from the block
	always @(posedge clk) begin : result_watch
		res_word_t got;
		if (arst_n && res.valid && res.ready) begin
			got.conn_state_out = res.conn_state_out;
			got.send_action = send_action_t'(res.send_action);
			got.notify = notify_t'(res.notify);
			got.rejected = res.rejected;
			got.unacked_seq = res.unacked_seq;
			got.recv_next_seq = res.recv_next_seq;
			trk.check_result(got);
		end
	end

	// Result side back-pressure
	initial begin : result_stall
		int hold;
		res.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			hold = idle_len();
			if (hold > 0) begin
				res.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			res.ready <= 1'b1;
			if ($urandom_range(0, 9) == 0)
				repeat ($urandom_range(50, 200)) @(posedge clk);
			else
				repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	initial begin : stimulus
		logic [31:0] isn_plan [6];
		logic [31:0] di;
		int          p;
		int          i;
		trk = new();
		src_steady = 1'b0;
		arst_n = 1'b0;
		seg.valid = 1'b0;
		seg.command = 1'b0;
		seg.new_state = '0;
		seg.flag_syn = 1'b0;
		seg.flag_ack = 1'b0;
		seg.flag_rst = 1'b0;
		seg.flag_fin = 1'b0;
		seg.seg_seq = '0;
		seg.seg_ack = '0;
		seg.send_next = '0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		isn_plan[0] = 32'h0000_0000;
		isn_plan[1] = 32'hFFFF_FFFF;
		isn_plan[2] = 32'h7FFF_FFFF;
		isn_plan[3] = 32'h8000_0000;
		isn_plan[4] = $urandom;
		isn_plan[5] = $urandom;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed walk through the states; the send window wraps past zero
		di = 32'hFFFF_FFF0;
		write_isn(di);
		send_word(seg_of(1'b0, 1'b0, 1'b0, 1'b0, '0, '0, '0));
		send_word(seg_of(1'b1, 1'b1, 1'b1, 1'b1, '1, '1, '1));
		send_word(load_of(4'hF));
		send_word(load_of(CODE_LISTEN));
		send_word(seg_of(1'b1, 1'b0, 1'b0, 1'b0, 32'd123, '0, '0));
		// bad ack in syn_sent, then an accepted reset
		send_word(load_of(CODE_SYN_SENT));
		send_word(seg_of(1'b1, 1'b1, 1'b0, 1'b0, '0, di, di + 32'd16));
		send_word(seg_of(1'b0, 1'b1, 1'b1, 1'b0, '0, di + 32'd1, di + 32'd16));
		// SYN alone opens the passive side
		send_word(load_of(CODE_SYN_SENT));
		send_word(seg_of(1'b1, 1'b0, 1'b0, 1'b0, '1, di + 32'd1, di + 32'd16));
		send_word(seg_of(1'b0, 1'b1, 1'b0, 1'b1, '0, di + 32'd1, di + 32'd16));
		// SYN+ACK connects
		send_word(load_of(CODE_SYN_SENT));
		send_word(seg_of(1'b1, 1'b1, 1'b0, 1'b0, 32'h1000, di + 32'd4, di + 32'd16));
		send_word(seg_of(1'b1, 1'b1, 1'b0, 1'b0, 32'h1001, 32'h100, 32'h200));
		send_word(seg_of(1'b0, 1'b1, 1'b0, 1'b0, 32'h1001, 32'h100, 32'h200));
		// RST without ACK is passed over, the FIN still counts
		send_word(seg_of(1'b0, 1'b0, 1'b1, 1'b1, 32'h1001, '0, '0));
		// closing sequences from finwait1
		send_word(load_of(CODE_FINWAIT1));
		send_word(seg_of(1'b0, 1'b1, 1'b0, 1'b1, 32'h1002, 32'h180, 32'h200));
		send_word(seg_of(1'b0, 1'b1, 1'b0, 1'b1, 32'h1003, 32'h190, 32'h200));
		send_word(load_of(CODE_FINWAIT1));
		send_word(seg_of(1'b0, 1'b1, 1'b0, 1'b1, 32'h1003, 32'h190, 32'h200));
		send_word(seg_of(1'b0, 1'b0, 1'b0, 1'b0, 32'h1004, 32'h1A0, 32'h200));
		send_word(load_of(CODE_FINWAIT1));
		send_word(seg_of(1'b0, 1'b1, 1'b0, 1'b0, 32'h1004, 32'h1A0, 32'h200));
		send_word(seg_of(1'b0, 1'b1, 1'b0, 1'b1, 32'h1004, 32'h1B0, 32'h200));
		send_word(load_of(CODE_LASTACK));
		send_word(seg_of(1'b0, 1'b1, 1'b0, 1'b0, 32'h1005, 32'h1B0, 32'h200));
		send_word(load_of(CODE_ESTAB));
		send_word(seg_of(1'b0, 1'b1, 1'b1, 1'b0, 32'h1005, 32'h1B0, 32'h200));
		drain();

		// Random phases, one initial sequence each
		for (p = 0; p < 6; p++) begin
			write_isn(isn_plan[p]);
			for (i = 0; i < PHASE_WORDS; i++) begin
				if (i % 50 == 0)
					src_steady = ($urandom_range(0, 3) == 0);
				send_word(next_segment());
			end
			drain();
		end

		repeat (8) @(posedge clk);
		if (trk.mismatches == 0 && trk.due.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/tcprx_pkg.sv
hw/rtl/tcprx_if.sv
hw/rtl/tcprx_step.sv
hw/rtl/tcp_connection_receive_fsm.sv
tb/tcp_connection_receive_fsm_tb.sv
